@@ hw/rtl/ist_pkg.sv @@
// shared constants and codes for the interval set tracker
`timescale 1ns / 1ps

package ist_pkg;

    // default sizes of the tracker
    localparam int DEF_MAX_INTERVALS = 16;
    localparam int DEF_ADDR_WIDTH    = 32;

    // fixed field widths on the streams
    localparam int FIELD_ADDR_W = 32;
    localparam int IN_TDATA_W   = 2 * FIELD_ADDR_W;
    localparam int OUT_CNT_W    = 5;
    localparam int STATUS_W     = 2;
    localparam int OUT_TDATA_W  = OUT_CNT_W + STATUS_W + 1;

    // request kinds carried on tuser
    typedef enum logic {
        OP_MARK  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

@@ hw/rtl/ist_table.sv @@
// interval table storage: one write port, one registered read port
`timescale 1ns / 1ps

module ist_table #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/interval_set_tracker_unit.sv @@
// interval set tracker top level: sequencer around the interval table
`timescale 1ns / 1ps

// Keeps a sorted table of up to MAX_INTERVALS disjoint closed address intervals.
// A mark request (tuser 0) inserts [first, last] and merges every stored interval
// that overlaps it or shares an endpoint; a query request (tuser 1) reports
// whether first lies inside a stored interval. Each request gives one result.
// The block takes one request at a time and drops s_tready until its result is
// loaded into the output register; a result waiting there does not stop the next
// request. All work goes through the single read port of the table, which reads
// one entry at a time: a query visits entries in order until one covers first;
// a mark finds the first entry that reaches first, absorbs overlapping entries,
// shifts the tail up or down and writes the merged interval, then waits for the
// output register if it is still full. Reset empties the table at once; no clearing pass.

module interval_set_tracker_unit
    import ist_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS,
    parameter int ADDR_WIDTH    = DEF_ADDR_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // first_addr[31:0], last_addr[63:32]
    input  logic                   s_tuser,   // operation[0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // covered[0], status[2:1], interval_count[7:3]
);

    localparam int EW = (ADDR_WIDTH < FIELD_ADDR_W) ? ADDR_WIDTH : FIELD_ADDR_W;
    localparam int IW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_QWAIT,
        S_QCMP,
        S_FWAIT,
        S_FCMP,
        S_MWAIT,
        S_MCMP,
        S_PLAN,
        S_UWAIT,
        S_UCMP,
        S_DWAIT,
        S_DCMP,
        S_WRITE,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [EW-1:0]          ns_reg, ns_next;
    logic [EW-1:0]          ne_reg, ne_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          i0_reg, i0_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [IW-1:0]          wp_reg, wp_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   cov_reg, cov_next;
    status_t                st_reg, st_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   tbl_we;
    logic [IW-1:0]          tbl_waddr;
    logic [2*EW-1:0]        tbl_wdata;
    logic [2*EW-1:0]        tbl_rdata;
    logic [EW-1:0]          ent_lo, ent_hi;
    logic [EW-1:0]          in_first, in_last;
    logic [CW-1:0]          idx_inc, i0_inc, merged;
    logic                   idx_last;

    ist_table #(
        .DEPTH  (MAX_INTERVALS),
        .DATA_W (2 * EW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_idx  (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_idx  (idx_reg[IW-1:0]),
        .rd_data (tbl_rdata)
    );

    // field unpacking and shared helpers
    assign in_first = s_tdata[EW-1:0];
    assign in_last  = s_tdata[FIELD_ADDR_W +: EW];
    assign ent_lo   = tbl_rdata[EW-1:0];
    assign ent_hi   = tbl_rdata[2*EW-1:EW];
    assign idx_inc  = idx_reg + CW'(1);
    assign i0_inc   = i0_reg + CW'(1);
    assign merged   = j_reg - i0_reg;
    assign idx_last = (idx_inc == count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sequencer next state and table write port
    always_comb
    begin
        state_next    = state_reg;
        ns_next       = ns_reg;
        ne_next       = ne_reg;
        idx_next      = idx_reg;
        i0_next       = i0_reg;
        j_next        = j_reg;
        wp_next       = wp_reg;
        count_next    = count_reg;
        cov_next      = cov_reg;
        st_next       = st_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        tbl_we        = 1'b0;
        tbl_waddr     = wp_reg;
        tbl_wdata     = tbl_rdata;

        // output register drains independently
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ns_next  = in_first;
                    ne_next  = in_last;
                    idx_next = '0;
                    i0_next  = '0;
                    j_next   = '0;
                    cov_next = 1'b0;
                    st_next  = ST_OK;
                    if (s_tuser == OP_QUERY)
                    begin
                        state_next = (count_reg == '0) ? S_DONE : S_QWAIT;
                    end
                    else if (in_first > in_last)
                    begin
                        st_next    = ST_IGNORED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? S_PLAN : S_FWAIT;
                    end
                end
            end

            // query walk
            S_QWAIT:
            begin
                state_next = S_QCMP;
            end
            S_QCMP:
            begin
                if ((ent_lo <= ns_reg) && (ns_reg <= ent_hi))
                begin
                    cov_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_QWAIT;
                end
            end

            // find first entry whose end reaches the new start
            S_FWAIT:
            begin
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                if (ent_hi < ns_reg)
                begin
                    if (idx_last)
                    begin
                        i0_next    = count_reg;
                        j_next     = count_reg;
                        state_next = S_PLAN;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_FWAIT;
                    end
                end
                else
                begin
                    // read data still holds this entry
                    i0_next    = idx_reg;
                    state_next = S_MCMP;
                end
            end

            // absorb entries that start no later than the growing end
            S_MWAIT:
            begin
                state_next = S_MCMP;
            end
            S_MCMP:
            begin
                if (ent_lo <= ne_reg)
                begin
                    if (ent_lo < ns_reg)
                    begin
                        ns_next = ent_lo;
                    end
                    if (ent_hi > ne_reg)
                    begin
                        ne_next = ent_hi;
                    end
                    if (idx_last)
                    begin
                        j_next     = count_reg;
                        state_next = S_PLAN;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_MWAIT;
                    end
                end
                else
                begin
                    j_next     = idx_reg;
                    state_next = S_PLAN;
                end
            end

            // choose between opening a slot, closing a gap, a plain write or a full status
            S_PLAN:
            begin
                wp_next = i0_inc[IW-1:0];
                if (merged == '0)
                begin
                    if (count_reg >= CW'(MAX_INTERVALS))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else if (i0_reg < count_reg)
                    begin
                        idx_next   = count_reg - CW'(1);
                        state_next = S_UWAIT;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (j_reg < count_reg)
                begin
                    idx_next   = j_reg;
                    state_next = S_DWAIT;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end

            // shift the tail up by one, from the top down
            S_UWAIT:
            begin
                state_next = S_UCMP;
            end
            S_UCMP:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = idx_inc[IW-1:0];
                if (idx_reg == i0_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_UWAIT;
                end
            end

            // move the tail down behind the merged slot
            S_DWAIT:
            begin
                state_next = S_DCMP;
            end
            S_DCMP:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = wp_reg;
                wp_next   = wp_reg + IW'(1);
                if (idx_last)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_DWAIT;
                end
            end

            // store the merged interval and update the count
            S_WRITE:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = i0_reg[IW-1:0];
                tbl_wdata  = {ne_reg, ns_reg};
                count_next = count_reg - merged + CW'(1);
                state_next = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {OUT_CNT_W'(count_reg), st_reg, cov_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ns_reg       <= '0;
            ne_reg       <= '0;
            idx_reg      <= '0;
            i0_reg       <= '0;
            j_reg        <= '0;
            wp_reg       <= '0;
            count_reg    <= '0;
            cov_reg      <= 1'b0;
            st_reg       <= ST_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ns_reg       <= ns_next;
            ne_reg       <= ne_next;
            idx_reg      <= idx_next;
            i0_reg       <= i0_next;
            j_reg        <= j_next;
            wp_reg       <= wp_next;
            count_reg    <= count_next;
            cov_reg      <= cov_next;
            st_reg       <= st_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

endmodule

@@ hw/rtl/ist_checker.sv @@
// port-level checks for the interval set tracker, bound to the top level
`timescale 1ns / 1ps

module ist_checker
    import ist_pkg::*;
#(
    parameter int MAX_INTERVALS = DEF_MAX_INTERVALS
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata    // covered[0], status[2:1], interval_count[7:3]
);

    logic [STATUS_W-1:0]  res_status;
    logic [OUT_CNT_W-1:0] res_count;

    assign res_status = m_tdata[STATUS_W:1];
    assign res_count  = m_tdata[OUT_TDATA_W-1:STATUS_W+1];

    // a request is worked on alone: no second request in the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while the previous one is in progress");

    // status is always one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_status == ST_OK || res_status == ST_IGNORED
                      || res_status == ST_FULL))
        else $error("undefined status code");

    // a covered address only comes with a good status
    a_covered_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (res_status == ST_OK))
        else $error("covered flag with a failing status");

    // the count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(res_count) <= MAX_INTERVALS))
        else $error("interval count above table size");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed while stalled");

endmodule

bind interval_set_tracker_unit ist_checker #(
    .MAX_INTERVALS (MAX_INTERVALS)
) u_ist_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/testbench.sv @@
// self-checking testbench for the interval set tracker unit
`timescale 1ns / 1ps

module testbench;
    import ist_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 6;
    localparam int          SPAN_CAP       = DEF_MAX_INTERVALS;
    localparam int          PHASES         = 16;
    localparam int          PHASE_REQUESTS = 47;
    localparam int          CALM_PHASES    = 2;
    localparam int          HOLD_PHASE     = 4;
    localparam int          SETTLE_PHASE   = 8;
    localparam int          LONG_HOLD      = 400;
    localparam int          DRAIN_CYCLES   = 4 * SPAN_CAP + 16;
    localparam int          STALL_LIMIT    = 4000;
    localparam logic [31:0] REGION_SPAN    = 32'h1000_0000;
    localparam logic [31:0] ADDR_TOP       = 32'hFFFF_FFFF;

    // one result as it sits on m_tdata
    typedef struct packed {
        logic [OUT_CNT_W-1:0] count;
        status_t              status;
        logic                 covered;
    } tracker_result_t;

    // one row of the directed table
    typedef struct packed {
        op_t             op;
        logic [31:0]     first_addr;
        logic [31:0]     last_addr;
        logic            typed;
        tracker_result_t want;
    } stim_row_t;

    // how marks are spread over the current address region
    typedef enum logic {
        MIX_SPARSE = 1'b0,
        MIX_DENSE  = 1'b1
    } mix_t;

    localparam int DIRECTED_ROWS = 21;

    // directed table: typed results only where they are plain to see
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty table after reset
        '{OP_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1, '{5'd0, ST_OK, 1'b0}},
        // start after end on an empty table
        '{OP_MARK,  32'h0000_0005, 32'h0000_0003, 1'b1, '{5'd0, ST_IGNORED, 1'b0}},
        // single points at both ends of the address space
        '{OP_MARK,  32'h0000_0000, 32'h0000_0000, 1'b1, '{5'd1, ST_OK, 1'b0}},
        '{OP_MARK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{5'd2, ST_OK, 1'b0}},
        '{OP_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1, '{5'd2, ST_OK, 1'b1}},
        '{OP_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{5'd2, ST_OK, 1'b1}},
        '{OP_QUERY, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{5'd2, ST_OK, 1'b0}},
        // adjacent point stays a separate entry
        '{OP_MARK,  32'h0000_0001, 32'h0000_0001, 1'b1, '{5'd3, ST_OK, 1'b0}},
        '{OP_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{5'd3, ST_OK, 1'b0}},
        // start after end at the extremes
        '{OP_MARK,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{5'd3, ST_IGNORED, 1'b0}},
        // shared endpoint merges, adjacency does not
        '{OP_MARK,  32'd100, 32'd200, 1'b0, '0},
        '{OP_MARK,  32'd200, 32'd300, 1'b0, '0},
        '{OP_MARK,  32'd301, 32'd400, 1'b0, '0},
        '{OP_MARK,  32'd500, 32'd600, 1'b0, '0},
        '{OP_MARK,  32'd700, 32'd800, 1'b0, '0},
        // one mark swallowing several entries
        '{OP_MARK,  32'd150, 32'd750, 1'b0, '0},
        '{OP_QUERY, 32'd750, 32'd0,   1'b0, '0},
        '{OP_QUERY, 32'd801, 32'd0,   1'b0, '0},
        // gap filler touching neighbours on both sides
        '{OP_MARK,  32'd2,   32'd99,  1'b0, '0},
        '{OP_MARK,  32'd0,   32'd1,   1'b0, '0},
        '{OP_QUERY, 32'd401, 32'd0,   1'b0, '0}
    };

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // first_addr[31:0], last_addr[63:32]
    logic                   s_tuser  = 1'b0; // operation[0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // covered[0], status[2:1], interval_count[7:3]

    // predictor copy of the interval table
    logic [31:0]     span_lo [SPAN_CAP];
    logic [31:0]     span_hi [SPAN_CAP];
    int              span_count = 0;

    tracker_result_t pending_results [$];
    int              mismatches    = 0;
    int              quiet_cycles  = 0;
    bit              idle_on       = 1'b0;
    bit              long_hold_req = 1'b0;
    logic [31:0]     region_base   = '0;
    logic [31:0]     dense_window  = '0;
    mix_t            mix           = MIX_SPARSE;

    always #(CLK_PERIOD / 2) clk = ~clk;

    interval_set_tracker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // advance the predicted table by one request and give its result
    function automatic tracker_result_t apply_request(input op_t op, input logic [31:0] lo,
                                                      input logic [31:0] hi);
        tracker_result_t r;
        int              first_hit;
        int              scan;
        int              absorbed;
        int              k;
        logic [31:0]     new_lo;
        logic [31:0]     new_hi;
        r.covered = 1'b0;
        r.status  = ST_OK;
        if (op == OP_QUERY)
        begin
            for (k = 0; k < span_count; k++)
                if (span_lo[k] <= lo && lo <= span_hi[k])
                    r.covered = 1'b1;
        end
        else if (lo > hi)
        begin
            r.status = ST_IGNORED;
        end
        else
        begin
            new_lo    = lo;
            new_hi    = hi;
            first_hit = 0;
            // first entry whose end reaches the new start
            while (first_hit < span_count && span_hi[first_hit] < lo)
                first_hit++;
            // take in every entry starting no later than the growing end
            scan = first_hit;
            while (scan < span_count && span_lo[scan] <= new_hi)
            begin
                if (span_lo[scan] < new_lo)
                    new_lo = span_lo[scan];
                if (span_hi[scan] > new_hi)
                    new_hi = span_hi[scan];
                scan++;
            end
            absorbed = scan - first_hit;
            if (absorbed == 0 && span_count >= SPAN_CAP)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                if (absorbed == 0)
                begin
                    // open a slot by shifting the tail up
                    for (k = span_count; k > first_hit; k--)
                    begin
                        span_lo[k] = span_lo[k - 1];
                        span_hi[k] = span_hi[k - 1];
                    end
                end
                else
                begin
                    // close the gap left by the merged entries
                    for (k = scan; k < span_count; k++)
                    begin
                        span_lo[first_hit + 1 + k - scan] = span_lo[k];
                        span_hi[first_hit + 1 + k - scan] = span_hi[k];
                    end
                end
                span_lo[first_hit] = new_lo;
                span_hi[first_hit] = new_hi;
                span_count         = span_count - absorbed + 1;
            end
        end
        r.count = OUT_CNT_W'(span_count);
        return r;
    endfunction

    // offer one request and log its expected result once accepted
    task automatic offer_request(input op_t op, input logic [31:0] first_addr,
                                 input logic [31:0] last_addr, input int gap,
                                 input logic typed, input tracker_result_t typed_result);
        tracker_result_t predicted;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {last_addr, first_addr};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(op, first_addr, last_addr);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // choose a random request, mostly aimed at the current region and stored edges
    task automatic pick_random_request(output op_t op, output logic [31:0] first_addr,
                                       output logic [31:0] last_addr);
        int          roll;
        int          idx;
        int          kind;
        logic [31:0] len;
        logic [31:0] x;
        logic [31:0] y;
        roll       = $urandom_range(0, 99);
        kind       = $urandom_range(0, 4);
        len        = $urandom_range(0, 40);
        idx        = (span_count > 0) ? $urandom_range(0, span_count - 1) : 0;
        op         = OP_MARK;
        first_addr = region_base + $urandom_range(0, REGION_SPAN - 1);
        last_addr  = $urandom;
        if (roll < 30)
        begin
            op = OP_QUERY;
            if (span_count > 0 && roll < 18)
            begin
                // probe just around a stored interval
                case (kind)
                    0:       first_addr = span_lo[idx] - 1;
                    1:       first_addr = span_lo[idx];
                    2:       first_addr = span_hi[idx];
                    3:       first_addr = span_hi[idx] + 1;
                    default: first_addr = span_lo[idx] + ((span_hi[idx] - span_lo[idx]) >> 1);
                endcase
            end
            else if (roll < 24)
            begin
                first_addr = $urandom;
            end
        end
        else if (roll < 38)
        begin
            // start after end, spread over the full width
            x = $urandom;
            y = $urandom;
            if (x == y)
                y = x ^ 32'h1;
            first_addr = (x > y) ? x : y;
            last_addr  = (x > y) ? y : x;
        end
        else if (roll < 58 && span_count > 0)
        begin
            // start on or just past a stored end
            if (kind < 2)
            begin
                first_addr = span_hi[idx];
                if (kind == 1 && span_hi[idx] != ADDR_TOP)
                    first_addr = span_hi[idx] + 1;
                last_addr = (first_addr > ADDR_TOP - len) ? ADDR_TOP : first_addr + len;
            end
            // end on or just before a stored start
            else
            begin
                last_addr = span_lo[idx];
                if (kind > 2 && span_lo[idx] != 0)
                    last_addr = span_lo[idx] - 1;
                first_addr = (last_addr < len) ? 32'h0 : last_addr - len;
            end
        end
        else if (mix == MIX_SPARSE)
        begin
            first_addr = region_base + $urandom_range(0, REGION_SPAN - 32'h1001);
            last_addr  = first_addr + $urandom_range(0, 32'hFFF);
        end
        else
        begin
            first_addr = region_base + dense_window + $urandom_range(0, 511);
            last_addr  = first_addr + len;
        end
    endtask

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        tracker_result_t want;
        tracker_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result %h arrived with no request outstanding", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.covered !== want.covered)
                begin
                    $display("%0t: covered mismatch: expected %0d, got %0d",
                             $time, want.covered, got.covered);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, got.status);
                    mismatches++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t: interval_count mismatch: expected %0d, got %0d",
                             $time, want.count, got.count);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: nothing moved for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stall bursts and one long hold-off
    initial
    begin : result_sink
        int hold;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 11);
            end
            else
            begin
                hold = 0;
            end
            m_tready <= (hold == 0);
            repeat ((hold > 0) ? hold - 1 : 0) @(negedge clk);
        end
    end

    // request side: reset, directed table, then random phases
    initial
    begin : stimulus
        op_t         op;
        logic [31:0] first_addr;
        logic [31:0] last_addr;
        int          phase;
        int          sent;
        int          gap;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i].op, directed_rows[i].first_addr,
                          directed_rows[i].last_addr, 0, directed_rows[i].typed,
                          directed_rows[i].want);

        // each phase works in a fresh region of the address space
        for (phase = 0; phase < PHASES; phase++)
        begin
            region_base  = REGION_SPAN * phase;
            dense_window = $urandom_range(0, 32'h0FFF_0000);
            mix          = mix_t'($urandom_range(0, 1));
            idle_on      = (phase < PHASES - CALM_PHASES) && (phase != HOLD_PHASE)
                           && ($urandom_range(0, 3) != 0);
            // sender keeps pushing while results are held back
            if (phase == HOLD_PHASE)
                long_hold_req = 1'b1;
            // sender waits for every outstanding result
            if (phase == SETTLE_PHASE)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            for (sent = 0; sent < PHASE_REQUESTS; sent++)
            begin
                pick_random_request(op, first_addr, last_addr);
                gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
                offer_request(op, first_addr, last_addr, gap, 1'b0, '0);
            end
            // fold everything up to the end of this region into one interval
            offer_request(OP_MARK, 32'h0, region_base + (REGION_SPAN - 1), 0, 1'b0, '0);
        end

        // drain outstanding results, then allow the block to settle
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ist_pkg.sv
hw/rtl/ist_table.sv
hw/rtl/interval_set_tracker_unit.sv
hw/rtl/ist_checker.sv
sim/testbench.sv
